/* sv/multi_key_debounce_long_press_assert.svh */
// ----------------------------------------------------------------------------
// multi_key_debounce_long_press assertion macros
// shared property shapes for the debounce block checks
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define MULTI_KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// same-cycle implication
`define MKDLP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkdlp check failed");

// next-cycle implication
`define MKDLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mkdlp check failed");

`endif

/* sv/mkdlp_pkg.sv */
// ----------------------------------------------------------------------------
// mkdlp_pkg
// types and constants of the multi-key debouncer
// ----------------------------------------------------------------------------
`default_nettype none

package mkdlp_pkg;

   localparam int NUM_KEYS    = 4;
   localparam int KEY_IDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CNT_W       = 16;
   localparam int SEL_W       = 3;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [SEL_W-1:0] SEL_LONG      = 3'd4;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSED_LEVEL = 1'd1;

   // per-key result of one tick
   typedef struct packed {
      logic press_hit;
      logic long_hit;
      logic stable;
   } key_evt_type;

endpackage

`default_nettype wire

/* sv/mkdlp_key.sv */
// ----------------------------------------------------------------------------
// mkdlp_key
// one key lane: three-sample filter, accepted level and timeout counter
// ----------------------------------------------------------------------------
`default_nettype none

module mkdlp_key (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          tick,
   input  wire logic                          level,
   input  wire logic                          pressed_level,
   input  wire logic [mkdlp_pkg::CNT_W-1:0]   timeout_ticks,
   output mkdlp_pkg::key_evt_type             evt
);
   import mkdlp_pkg::*;

   logic             stage_a_ff;
   logic             stage_b_ff;
   logic             accepted_ff;
   logic             accepted_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_dec;
   logic             agree;
   logic             is_pressed;

   // after the shift: a = level, b = stage_a, c = stage_b
   always_comb begin
      agree       = (level == stage_a_ff) && (stage_a_ff == stage_b_ff);
      is_pressed  = (stage_b_ff == pressed_level);
      count_dec   = count_ff - CNT_W'(1);
      accepted_in = accepted_ff;
      count_in    = count_ff;
      evt         = '0;
      if (tick && agree) begin
         if (stage_b_ff != accepted_ff) begin
            accepted_in = stage_b_ff;
            if (is_pressed) begin
               count_in      = timeout_ticks;
               evt.press_hit = 1'b1;
            end
         end else if (count_dec == '0) begin
            count_in     = timeout_ticks;
            evt.long_hit = is_pressed;
         end else begin
            count_in = count_dec;
         end
      end
      evt.stable = accepted_in;
   end

   // reset value is the released level for the reset polarity (pressed = 0)
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff  <= 1'b1;
         stage_b_ff  <= 1'b1;
         accepted_ff <= 1'b1;
         count_ff    <= TIMEOUT_RESET;
      end else begin
         if (tick) begin
            stage_a_ff <= level;
            stage_b_ff <= stage_a_ff;
         end
         accepted_ff <= accepted_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

/* sv/multi_key_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// multi_key_debounce_long_press
// four-key debouncer with per-key press flags and a shared long-press flag
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser: op, tdata: key_levels, flag_select
//  rsp      out  rsp_tvalid/tready    tdata: press_flags, long_flag,
//                                     read_value, stable_levels
//  csr      in   csr_valid/ready      csr_index, csr_data
//
//  one word per clock unless the result stalls; each word passes the input
//  register, then the result register. all key lanes update in the cycle the
//  word leaves the input register. a stalled result holds the input register,
//  which still takes one more word. reset is synchronous and takes effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_debounce_long_press (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [mkdlp_pkg::REQ_TDATA_W-1:0]    req_tdata,  // key_levels, flag_select
   input  wire logic                                 req_tuser,  // op
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // press_flags, long_flag, read_value, stable_levels
   output logic      [mkdlp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mkdlp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mkdlp_pkg::CNT_W-1:0]          csr_data
);
   import mkdlp_pkg::*;

   logic [CNT_W-1:0]       timeout_ticks_ff;
   logic                   pressed_level_ff;

   logic                   s1_valid_ff;
   logic                   s1_op_ff;
   logic [NUM_KEYS-1:0]    s1_levels_ff;
   logic [SEL_W-1:0]       s1_sel_ff;
   logic                   s1_fire;
   logic                   tick;
   logic                   read_fire;

   logic [NUM_KEYS-1:0]    press_ff;
   logic [NUM_KEYS-1:0]    press_in;
   logic                   long_ff;
   logic                   long_in;
   logic                   read_value;
   logic [NUM_KEYS-1:0]    press_hits;
   logic [NUM_KEYS-1:0]    long_hits;
   logic [NUM_KEYS-1:0]    stable_levels;
   logic [KEY_IDX_W-1:0]   key_idx;

   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   key_evt_type            evt [NUM_KEYS];

   assign csr_ready  = 1'b1;
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign tick       = s1_fire && (s1_op_ff == OP_TICK);
   assign read_fire  = s1_fire && (s1_op_ff == OP_READ);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_RESET;
         pressed_level_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_data;
            CSR_PRESSED_LEVEL: pressed_level_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_op_ff     <= req_tuser;
         s1_levels_ff <= req_tdata[NUM_KEYS-1:0];
         s1_sel_ff    <= req_tdata[NUM_KEYS +: SEL_W];
      end
   end

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      mkdlp_key u_key (
         .clock         (clock),
         .reset         (reset),
         .tick          (tick),
         .level         (s1_levels_ff[k]),
         .pressed_level (pressed_level_ff),
         .timeout_ticks (timeout_ticks_ff),
         .evt           (evt[k])
      );
      assign press_hits[k]    = evt[k].press_hit;
      assign long_hits[k]     = evt[k].long_hit;
      assign stable_levels[k] = evt[k].stable;
   end

   // flag update and read-clear
   always_comb begin
      press_in   = press_ff | press_hits;
      long_in    = long_ff | (|long_hits);
      read_value = 1'b0;
      key_idx    = s1_sel_ff[KEY_IDX_W-1:0];
      if (read_fire) begin
         if (s1_sel_ff == SEL_LONG) begin
            read_value = long_ff;
            long_in    = 1'b0;
         end else if (s1_sel_ff < SEL_W'(NUM_KEYS)) begin
            read_value        = press_ff[key_idx];
            press_in[key_idx] = 1'b0;
         end
      end
      rsp_data_in = RSP_TDATA_W'({stable_levels, read_value, long_in, press_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff <= '0;
         long_ff  <= 1'b0;
      end else begin
         press_ff <= press_in;
         long_ff  <= long_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`include "multi_key_debounce_long_press_assert.svh"

   // only a full result register that is stalled can hold off the input side
   `MKDLP_ASSERT_NOW(a_ready_only_on_stall, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)
   // a long-press read leaves the flag clear
   `MKDLP_ASSERT_NEXT(a_long_read_clears, clock, reset, read_fire && (s1_sel_ff == SEL_LONG), !long_ff)
   // a read never raises a press flag
   `MKDLP_ASSERT_NEXT(a_read_no_new_press, clock, reset, read_fire, (press_ff & ~$past(press_ff)) == '0)

endmodule

`default_nettype wire
